>>> hw/rtl/glyph_outline_decomposer_macros.svh
// Assertion macros for the glyph outline decomposer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GLYPH_OUTLINE_DECOMPOSER_MACROS_SVH
`define GLYPH_OUTLINE_DECOMPOSER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GOD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/god_pkg.sv
// Package for the glyph outline decomposer: command kinds, tags, FSM states
// and the command and status structs between controller and datapath. No dependencies.
package god_pkg;

    localparam logic [2:0] KIND_MOVE  = 3'd0;
    localparam logic [2:0] KIND_LINE  = 3'd1;
    localparam logic [2:0] KIND_QUAD  = 3'd2;
    localparam logic [2:0] KIND_CUBIC = 3'd3;
    localparam logic [2:0] KIND_CLOSE = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    localparam logic [1:0] TAG_CONIC    = 2'd0;
    localparam logic [1:0] TAG_ON       = 2'd1;
    localparam logic [1:0] TAG_CUBIC    = 2'd2;
    localparam logic [1:0] TAG_RESERVED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_START,
        ST_RD_PT,
        ST_PT,
        ST_ERROR,
        ST_CLOSE
    } god_state_t;

    // Which operand a coordinate slot of a command takes.
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_RD,
        SRC_Q,
        SRC_A,
        SRC_B,
        SRC_MID,
        SRC_START,
        SRC_FIRST
    } god_src_t;

    typedef struct packed {
        logic       rd_en;
        logic       ld_first;
        logic       ld_start;
        logic       start_mid;
        logic       start_last;
        logic       ld_q;
        logic       ld_a;
        logic       ld_b;
        logic       out_load;
        logic [2:0] out_kind;
        god_src_t   src1;
        god_src_t   src2;
        god_src_t   src3;
        logic       out_last;
    } god_cmd_t;

    typedef struct packed {
        logic       out_busy;
        logic [1:0] rd_tag;
        logic [1:0] first_tag;
    } god_status_t;

endpackage

>>> hw/rtl/glyph_outline_decomposer.sv
// Top level of the glyph outline decomposer.
// Depends on god_pkg, god_ctrl and god_datapath.
//
// Usage: outline points come in on the point channel (point_x, point_y,
// curve_tag, contour_end, outline_end with valid and ready), one point per
// transfer. Points that do not end a contour are stored in a buffer of
// MAX_POINTS entries and produce nothing; one that finds the buffer full
// produces an error. When the contour ends, the controller walks the buffer
// through the single read port of the buffer memory: setup (two reads, then
// the move), then a read and a handling step per walked point plus one final
// step, and at most one path command (move, line, quadratic, cubic, close or
// error) leaves the output register per step. run_last marks the last
// command that a point caused. No input is taken while a contour is walked.
// A stalled receiver holds the output register and freezes the walk.
// Reset clears the point count, the failure flag and the output valid;
// the buffer itself needs no clearing since only written entries are read.
module glyph_outline_decomposer
    import god_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic [1:0]                   curve_tag,
    input  logic                         contour_end,
    input  logic                         outline_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   path_kind,
    output logic signed [COORD_BITS-1:0] first_x,
    output logic signed [COORD_BITS:0]   first_y,
    output logic signed [COORD_BITS-1:0] second_x,
    output logic signed [COORD_BITS:0]   second_y,
    output logic signed [COORD_BITS-1:0] third_x,
    output logic signed [COORD_BITS:0]   third_y,
    output logic                         run_last
);

    // Index width covers the buffer; the count also holds MAX_POINTS itself.
    localparam int IDX_BITS = $clog2(MAX_POINTS);
    localparam int CNT_BITS = $clog2(MAX_POINTS + 1);

    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic [IDX_BITS-1:0] rd_addr;
    god_cmd_t            cmd;
    god_status_t         status;

    god_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_BITS   (IDX_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cend  (contour_end),
        .in_oend  (outline_end),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .cmd      (cmd),
        .status   (status)
    );

    god_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_x      (point_x),
        .wr_y      (point_y),
        .wr_tag    (curve_tag),
        .rd_addr   (rd_addr),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .path_kind (path_kind),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .third_x   (third_x),
        .third_y   (third_y),
        .run_last  (run_last)
    );

endmodule

>>> hw/rtl/god_datapath.sv
// Datapath of the glyph outline decomposer: point buffer memory, operand
// registers, midpoint adders and the output register. Uses god_pkg.
module god_datapath
    import god_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 24,
    parameter int IDX_BITS   = 5
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [IDX_BITS-1:0]          wr_addr,
    input  logic signed [COORD_BITS-1:0] wr_x,
    input  logic signed [COORD_BITS-1:0] wr_y,
    input  logic [1:0]                   wr_tag,
    input  logic [IDX_BITS-1:0]          rd_addr,
    input  god_cmd_t                     cmd,
    output god_status_t                  status,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [2:0]                   path_kind,
    output logic signed [COORD_BITS-1:0] first_x,
    output logic signed [COORD_BITS:0]   first_y,
    output logic signed [COORD_BITS-1:0] second_x,
    output logic signed [COORD_BITS:0]   second_y,
    output logic signed [COORD_BITS-1:0] third_x,
    output logic signed [COORD_BITS:0]   third_y,
    output logic                         run_last
);

    localparam int W = COORD_BITS;

    logic signed [W-1:0] mem_x [MAX_POINTS];
    logic signed [W-1:0] mem_y [MAX_POINTS];
    logic [1:0]          mem_t [MAX_POINTS];

    logic signed [W-1:0] rd_x_reg, rd_y_reg;
    logic [1:0]          rd_t_reg;
    logic signed [W-1:0] f_x_reg, f_y_reg, s_x_reg, s_y_reg;
    logic signed [W-1:0] q_x_reg, q_y_reg, a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic [1:0]          first_t_reg;
    logic                out_valid_reg;
    logic [2:0]          kind_reg;
    logic signed [W-1:0] o1x_reg, o2x_reg, o3x_reg;
    logic signed [W:0]   o1y_reg, o2y_reg, o3y_reg;
    logic                last_reg;

    logic signed [W-1:0] mid_x, mid_y, smid_x, smid_y;
    logic signed [W-1:0] v1x, v1y, v2x, v2y, v3x, v3y;

    // Truncating halving of a sum toward zero.
    function automatic logic signed [W-1:0] half_sum(input logic signed [W-1:0] a,
                                                      input logic signed [W-1:0] b);
        logic signed [W:0] s;
        logic signed [W:0] h;
        begin
            s = {a[W-1], a} + {b[W-1], b};
            h = (s + {{W{1'b0}}, s[W]}) >>> 1;
            half_sum = h[W-1:0];
        end
    endfunction

    function automatic logic signed [W:0] neg(input logic signed [W-1:0] v);
        begin
            neg = -{v[W-1], v};
        end
    endfunction

    assign mid_x  = half_sum(q_x_reg, rd_x_reg);
    assign mid_y  = half_sum(q_y_reg, rd_y_reg);
    assign smid_x = half_sum(f_x_reg, rd_x_reg);
    assign smid_y = half_sum(f_y_reg, rd_y_reg);

    // In the first slot the midpoint is that of the first and last points,
    // which only the move of a contour uses.
    always_comb
    begin
        v1x = '0; v1y = '0; v2x = '0; v2y = '0; v3x = '0; v3y = '0;
        case (cmd.src1)
            SRC_RD:    begin v1x = rd_x_reg; v1y = rd_y_reg; end
            SRC_Q:     begin v1x = q_x_reg;  v1y = q_y_reg;  end
            SRC_A:     begin v1x = a_x_reg;  v1y = a_y_reg;  end
            SRC_MID:   begin v1x = smid_x;   v1y = smid_y;   end
            SRC_START: begin v1x = s_x_reg;  v1y = s_y_reg;  end
            SRC_FIRST: begin v1x = f_x_reg;  v1y = f_y_reg;  end
            default:   begin v1x = '0;       v1y = '0;       end
        endcase
        case (cmd.src2)
            SRC_RD:    begin v2x = rd_x_reg; v2y = rd_y_reg; end
            SRC_B:     begin v2x = b_x_reg;  v2y = b_y_reg;  end
            SRC_MID:   begin v2x = mid_x;    v2y = mid_y;    end
            SRC_START: begin v2x = s_x_reg;  v2y = s_y_reg;  end
            default:   begin v2x = '0;       v2y = '0;       end
        endcase
        case (cmd.src3)
            SRC_RD:    begin v3x = rd_x_reg; v3y = rd_y_reg; end
            SRC_START: begin v3x = s_x_reg;  v3y = s_y_reg;  end
            default:   begin v3x = '0;       v3y = '0;       end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_t[wr_addr] <= wr_tag;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_t_reg <= mem_t[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_first)
        begin
            f_x_reg     <= rd_x_reg;
            f_y_reg     <= rd_y_reg;
            first_t_reg <= rd_t_reg;
        end
        if (cmd.ld_start)
        begin
            if (cmd.start_last)
            begin
                s_x_reg <= rd_x_reg;
                s_y_reg <= rd_y_reg;
            end
            else if (cmd.start_mid)
            begin
                s_x_reg <= smid_x;
                s_y_reg <= smid_y;
            end
            else
            begin
                s_x_reg <= f_x_reg;
                s_y_reg <= f_y_reg;
            end
        end
        if (cmd.ld_q)
        begin
            q_x_reg <= rd_x_reg;
            q_y_reg <= rd_y_reg;
        end
        if (cmd.ld_a)
        begin
            a_x_reg <= rd_x_reg;
            a_y_reg <= rd_y_reg;
        end
        if (cmd.ld_b)
        begin
            b_x_reg <= rd_x_reg;
            b_y_reg <= rd_y_reg;
        end
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            o1x_reg  <= v1x;
            o1y_reg  <= neg(v1y);
            o2x_reg  <= v2x;
            o2y_reg  <= neg(v2y);
            o3x_reg  <= v3x;
            o3y_reg  <= neg(v3y);
            last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy  = out_valid_reg && !out_ready;
    assign status.rd_tag    = rd_t_reg;
    assign status.first_tag = first_t_reg;

    assign out_valid = out_valid_reg;
    assign path_kind = kind_reg;
    assign first_x   = o1x_reg;
    assign first_y   = o1y_reg;
    assign second_x  = o2x_reg;
    assign second_y  = o2y_reg;
    assign third_x   = o3x_reg;
    assign third_y   = o3y_reg;
    assign run_last  = last_reg;

endmodule

>>> hw/rtl/god_ctrl.sv
// Controller of the glyph outline decomposer: point counting, failure flag
// and the contour walk state machine. Uses god_pkg and the assertion macros.
`include "glyph_outline_decomposer_macros.svh"
module god_ctrl
    import god_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int IDX_BITS   = 5,
    parameter int CNT_BITS   = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cend,
    input  logic                in_oend,
    output logic                wr_en,
    output logic [IDX_BITS-1:0] wr_addr,
    output logic [IDX_BITS-1:0] rd_addr,
    output god_cmd_t            cmd,
    input  god_status_t         status
);

    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_POINTS);

    god_state_t          state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                failed_reg, failed_next;
    logic                oend_reg, oend_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] lim_reg, lim_next;
    logic                inq_reg, inq_next;   // holding a conic control in q
    logic [1:0]          cub_reg, cub_next;   // cubic phase: 0 none, 1 have a, 2 have b

    logic                accept;
    logic [CNT_BITS-1:0] last_idx;
    logic                walk_done;

    assign accept    = in_valid && in_ready;
    assign last_idx  = count_reg - CNT_BITS'(1);
    assign wr_addr   = count_reg[IDX_BITS-1:0];
    // The index counts one past the buffer, so the walk end never wraps.
    assign walk_done = idx_reg > lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            failed_reg <= 1'b0;
            oend_reg   <= 1'b0;
            idx_reg    <= '0;
            lim_reg    <= '0;
            inq_reg    <= 1'b0;
            cub_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            failed_reg <= failed_next;
            oend_reg   <= oend_next;
            idx_reg    <= idx_next;
            lim_reg    <= lim_next;
            inq_reg    <= inq_next;
            cub_reg    <= cub_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        failed_next = failed_reg;
        oend_next   = oend_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        inq_next    = inq_reg;
        cub_next    = cub_reg;
        in_ready    = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = idx_reg[IDX_BITS-1:0];
        cmd         = '0;
        cmd.src1    = SRC_ZERO;
        cmd.src2    = SRC_ZERO;
        cmd.src3    = SRC_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (failed_reg)
                    begin
                        if (in_oend)
                        begin
                            failed_next = 1'b0;
                            count_next  = '0;
                        end
                    end
                    else if (count_reg >= MAX_CNT)
                    begin
                        oend_next  = in_oend;
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_BITS'(1);
                        oend_next  = in_oend;
                        if (in_cend || in_oend)
                        begin
                            state_next = ST_RD_FIRST;
                        end
                    end
                end
            end
            ST_RD_FIRST:
            begin
                rd_addr    = '0;
                cmd.rd_en  = 1'b1;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                cmd.ld_first = 1'b1;
                rd_addr      = last_idx[IDX_BITS-1:0];
                cmd.rd_en    = 1'b1;
                state_next   = ST_START;
            end
            ST_START:
            begin
                // Read data holds the last point, first point is registered.
                inq_next = 1'b0;
                cub_next = '0;
                if (status.first_tag == TAG_CUBIC)
                begin
                    state_next = ST_ERROR;
                end
                else if (!status.out_busy)
                begin
                    cmd.ld_start = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_MOVE;
                    if (status.first_tag == TAG_CONIC)
                    begin
                        idx_next = '0;
                        if (status.rd_tag == TAG_ON)
                        begin
                            cmd.start_last = 1'b1;
                            cmd.src1       = SRC_RD;
                            lim_next       = last_idx - CNT_BITS'(1);
                        end
                        else
                        begin
                            cmd.start_mid = 1'b1;
                            cmd.src1      = SRC_MID;
                            lim_next      = last_idx;
                        end
                        // Conic first and one point: a wrapped quad still follows.
                    end
                    else
                    begin
                        cmd.src1 = SRC_FIRST;
                        idx_next = CNT_BITS'(1);
                        lim_next = last_idx;
                    end
                    state_next = ST_RD_PT;
                end
            end
            ST_RD_PT:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_PT;
            end
            ST_PT:
            begin
                // The point at idx_reg is in the read register. A stalled
                // output holds the walk here.
                if (!status.out_busy)
                begin
                    state_next = ST_RD_PT;
                    if (walk_done)
                    begin
                        // Past the end of the contour.
                        if (inq_reg)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_QUAD;
                            cmd.src1     = SRC_Q;
                            cmd.src2     = SRC_START;
                            cmd.out_last = 1'b1;
                            count_next   = '0;
                            failed_next  = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else if (cub_reg == 2'd2)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_CUBIC;
                            cmd.src1     = SRC_A;
                            cmd.src2     = SRC_B;
                            cmd.src3     = SRC_START;
                            cmd.out_last = 1'b1;
                            count_next   = '0;
                            failed_next  = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else if (cub_reg == 2'd1)
                        begin
                            state_next = ST_ERROR;
                        end
                        else
                        begin
                            state_next = ST_CLOSE;
                        end
                    end
                    else if (cub_reg == 2'd1)
                    begin
                        if (status.rd_tag != TAG_CUBIC)
                        begin
                            state_next = ST_ERROR;
                        end
                        else
                        begin
                            cmd.ld_b = 1'b1;
                            cub_next = 2'd2;
                            idx_next = idx_reg + CNT_BITS'(1);
                        end
                    end
                    else if (cub_reg == 2'd2)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_CUBIC;
                        cmd.src1     = SRC_A;
                        cmd.src2     = SRC_B;
                        cmd.src3     = SRC_RD;
                        cub_next     = '0;
                        idx_next     = idx_reg + CNT_BITS'(1);
                    end
                    else if (inq_reg)
                    begin
                        if (status.rd_tag == TAG_ON)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_QUAD;
                            cmd.src1     = SRC_Q;
                            cmd.src2     = SRC_RD;
                            inq_next     = 1'b0;
                            idx_next     = idx_reg + CNT_BITS'(1);
                        end
                        else if (status.rd_tag == TAG_CONIC)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_QUAD;
                            cmd.src1     = SRC_Q;
                            cmd.src2     = SRC_MID;
                            cmd.ld_q     = 1'b1;
                            idx_next     = idx_reg + CNT_BITS'(1);
                        end
                        else
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    else
                    begin
                        case (status.rd_tag)
                            TAG_ON:
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_LINE;
                                cmd.src1     = SRC_RD;
                            end
                            TAG_CONIC:
                            begin
                                cmd.ld_q = 1'b1;
                                inq_next = 1'b1;
                            end
                            default:
                            begin
                                cmd.ld_a = 1'b1;
                                cub_next = 2'd1;
                            end
                        endcase
                        idx_next = idx_reg + CNT_BITS'(1);
                    end
                end
            end
            ST_ERROR:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_ERROR;
                    cmd.out_last = 1'b1;
                    failed_next  = !oend_reg;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_CLOSE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_CLOSE;
                    cmd.out_last = 1'b1;
                    count_next   = '0;
                    failed_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GOD_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE,
        "input taken outside idle")
    `GOD_ASSERT_IMP(a_no_load_busy, clk, rst_n, cmd.out_load, !status.out_busy,
        "output overwritten while stalled")
    `GOD_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= MAX_CNT,
        "point count beyond buffer")
    `GOD_ASSERT_NEXT(a_error_to_idle, clk, rst_n,
        cmd.out_load && cmd.out_kind == KIND_ERROR, state_reg == ST_IDLE,
        "error not terminating the run")

endmodule

>>> verif/glyph_outline_decomposer_test.sv
// Self-checking testbench for glyph_outline_decomposer: outline points in, path commands out.
// Depends on god_pkg and the glyph_outline_decomposer RTL; a scoreboard class predicts results.
`timescale 1ns / 1ps

class path_scoreboard;
    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] ax;
        logic [24:0] ay;
        logic [23:0] bx;
        logic [24:0] by;
        logic [23:0] cx;
        logic [24:0] cy;
        logic        last;
    } path_cmd_t;

    path_cmd_t   pending[$];
    path_cmd_t   batch[$];
    logic signed [31:0] px[32];
    logic signed [31:0] py[32];
    logic [1:0]  ptag[32];
    int          npts;
    bit          failed;
    int          mismatches;

    function new();
        npts = 0;
        failed = 0;
        mismatches = 0;
    endfunction

    function logic signed [31:0] half_sum(logic signed [31:0] a, logic signed [31:0] b);
        return (a + b) / 2;
    endfunction

    function void push(logic [2:0] kind, logic signed [31:0] ax, logic signed [31:0] ay,
                       logic signed [31:0] bx, logic signed [31:0] by,
                       logic signed [31:0] cx, logic signed [31:0] cy);
        path_cmd_t c;
        logic signed [31:0] t;
        c.kind = kind;
        c.ax = ax[23:0];
        t = -ay;
        c.ay = t[24:0];
        c.bx = bx[23:0];
        t = -by;
        c.by = t[24:0];
        c.cx = cx[23:0];
        t = -cy;
        c.cy = t[24:0];
        c.last = 0;
        batch.push_back(c);
    endfunction

    // Walks the buffered contour; returns 1 when the tag sequence is bad.
    function bit walk();
        int last;
        int lim;
        int i;
        logic signed [31:0] sx, sy, qx, qy;
        bit wrapped;
        bit landed;
        last = npts - 1;
        lim = last;
        i = 0;
        sx = px[0];
        sy = py[0];
        wrapped = 0;
        if (ptag[0] == god_pkg::TAG_CUBIC) return 1;
        if (ptag[0] == god_pkg::TAG_CONIC)
        begin
            if (ptag[last] == god_pkg::TAG_ON)
            begin
                sx = px[last];
                sy = py[last];
                lim = last - 1;
            end
            else
            begin
                sx = half_sum(sx, px[last]);
                sy = half_sum(sy, py[last]);
            end
            i = -1;
        end
        push(god_pkg::KIND_MOVE, sx, sy, 0, 0, 0, 0);
        while (i < lim && !wrapped)
        begin
            i++;
            if (ptag[i] == god_pkg::TAG_ON)
            begin
                push(god_pkg::KIND_LINE, px[i], py[i], 0, 0, 0, 0);
            end
            else if (ptag[i] == god_pkg::TAG_CONIC)
            begin
                landed = 0;
                qx = px[i];
                qy = py[i];
                while (i < lim && !landed)
                begin
                    i++;
                    if (ptag[i] == god_pkg::TAG_ON)
                    begin
                        push(god_pkg::KIND_QUAD, qx, qy, px[i], py[i], 0, 0);
                        landed = 1;
                    end
                    else if (ptag[i] != god_pkg::TAG_CONIC)
                    begin
                        return 1;
                    end
                    else
                    begin
                        push(god_pkg::KIND_QUAD, qx, qy, half_sum(qx, px[i]),
                             half_sum(qy, py[i]), 0, 0);
                        qx = px[i];
                        qy = py[i];
                    end
                end
                if (!landed)
                begin
                    push(god_pkg::KIND_QUAD, qx, qy, sx, sy, 0, 0);
                    wrapped = 1;
                end
            end
            else
            begin
                if (i + 1 > lim || ptag[i + 1] != god_pkg::TAG_CUBIC) return 1;
                i += 2;
                if (i <= lim)
                begin
                    push(god_pkg::KIND_CUBIC, px[i-2], py[i-2], px[i-1], py[i-1],
                         px[i], py[i]);
                end
                else
                begin
                    push(god_pkg::KIND_CUBIC, px[i-2], py[i-2], px[i-1], py[i-1], sx, sy);
                    wrapped = 1;
                end
            end
        end
        if (!wrapped) push(god_pkg::KIND_CLOSE, 0, 0, 0, 0, 0, 0);
        return 0;
    endfunction

    // Notes one accepted point and queues the commands that it causes.
    function void note_point(logic [23:0] x, logic [23:0] y, logic [1:0] tag,
                             bit cend, bit oend);
        bit bad;
        bad = 0;
        batch.delete();
        if (failed)
        begin
            if (oend)
            begin
                failed = 0;
                npts = 0;
            end
            return;
        end
        if (oend) cend = 1;
        if (npts >= 32)
        begin
            bad = 1;
        end
        else
        begin
            px[npts] = $signed(x);
            py[npts] = $signed(y);
            ptag[npts] = tag;
            npts++;
            if (!cend) return;
            bad = walk();
        end
        if (bad)
        begin
            push(god_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0);
            failed = !oend;
        end
        npts = 0;
        if (oend) failed = 0;
        if (batch.size() > 0) batch[batch.size()-1].last = 1;
        foreach (batch[k]) pending.push_back(batch[k]);
    endfunction

    function void check_command(path_cmd_t got);
        path_cmd_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected command: want none, got kind %0d", got.kind);
            return;
        end
        want = pending.pop_front();
        if (got != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: want %0d %h %h %h %h %h %h %b, got %0d %h %h %h %h %h %h %b",
                         want.kind, want.ax, want.ay, want.bx, want.by, want.cx, want.cy,
                         want.last, got.kind, got.ax, got.ay, got.bx, got.by, got.cx,
                         got.cy, got.last);
        end
    endfunction
endclass

module glyph_outline_decomposer_test;
    import god_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [23:0] point_x = 0;
    logic signed [23:0] point_y = 0;
    logic [1:0]         curve_tag = 0;
    logic               contour_end = 0;
    logic               outline_end = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [2:0]         path_kind;
    logic signed [23:0] first_x, second_x, third_x;
    logic signed [24:0] first_y, second_y, third_y;
    logic               run_last;

    path_scoreboard     board;
    int                 cycle_count = 0;
    bit                 long_hold = 0;

    glyph_outline_decomposer dut (.*);

    always #1 clk = ~clk;

    // Run limit; the slowest legal run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("glyph_outline_decomposer_test: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls per command, plus one long hold-off window.
    initial
    begin
        int gap;
        board = new();
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0 || long_hold)
            begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
                while (long_hold) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_command('{path_kind, first_x, first_y, second_x, second_y,
                                  third_x, third_y, run_last});
        end
    end

    // Sends one point and notes it once the transfer happens. Valid stays
    // high after the transfer when the next point follows at once.
    task automatic send_point(logic [23:0] x, logic [23:0] y, logic [1:0] tag,
                              bit cend, bit oend, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        point_x <= x;
        point_y <= y;
        curve_tag <= tag;
        contour_end <= cend;
        outline_end <= oend;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_point(x, y, tag, cend, oend);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 255) - 128);
            default: return 24'($urandom);
        endcase
    endfunction

    // Sends a contour of random tags, not all of them well-formed, with random coordinates.
    task automatic send_contour(int len, bit oend, bit burst);
        logic [1:0] tags[$];
        int k;
        while (tags.size() < len)
        begin
            case ($urandom_range(0, 3))
                0: tags.push_back(TAG_ON);
                1: tags.push_back(TAG_CONIC);
                2: if (tags.size() > 0 || $urandom_range(0, 1))
                   begin
                       tags.push_back($urandom_range(0, 1) ? TAG_CUBIC : TAG_RESERVED);
                       tags.push_back(TAG_CUBIC);
                   end
                default: tags.push_back(TAG_RESERVED);
            endcase
        end
        while (tags.size() > len) tags.pop_back();
        if (tags[0] == TAG_CUBIC) tags[0] = TAG_ON;
        for (k = 0; k < len; k++)
            send_point(rand_coord(), rand_coord(), tags[k], k == len - 1,
                       oend && k == len - 1, burst);
    endtask

    initial
    begin
        int n;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, each path kind, conic start cases, errors, overflow.
        send_point(24'h7fffff, 24'h800000, TAG_ON, 0, 0, 0);
        send_point(24'h800000, 24'h7fffff, TAG_ON, 0, 0, 0);
        send_point(24'h000005, 24'hfffffb, TAG_CONIC, 0, 0, 0);
        send_point(24'h000003, 24'h000001, TAG_CONIC, 0, 0, 0);
        send_point(24'h000010, 24'h000020, TAG_ON, 1, 0, 0);
        send_point(24'h000007, 24'h000009, TAG_CONIC, 0, 0, 0);
        send_point(24'h000011, 24'hffffff, TAG_ON, 1, 0, 0);
        send_point(24'h000007, 24'h000009, TAG_CONIC, 0, 0, 0);
        send_point(24'hfffff3, 24'h000004, TAG_CONIC, 1, 0, 0);
        send_point(24'h000001, 24'h000002, TAG_ON, 0, 0, 0);
        send_point(24'h000003, 24'h000004, TAG_RESERVED, 0, 0, 0);
        send_point(24'h000005, 24'h000006, TAG_CUBIC, 0, 0, 0);
        send_point(24'h000007, 24'h000008, TAG_ON, 0, 0, 0);
        send_point(24'h000009, 24'h00000a, TAG_CUBIC, 0, 0, 0);
        send_point(24'h00000b, 24'h00000c, TAG_CUBIC, 1, 0, 0);
        send_point(24'h000001, 24'h000001, TAG_CUBIC, 1, 0, 0);
        send_point(24'h000002, 24'h000002, TAG_ON, 1, 0, 0);
        send_point(24'h000002, 24'h000002, TAG_ON, 0, 1, 0);
        send_point(24'h000001, 24'h000001, TAG_CONIC, 0, 0, 0);
        send_point(24'h000002, 24'h000002, TAG_RESERVED, 1, 1, 0);
        send_point(24'h000004, 24'h000004, TAG_RESERVED, 1, 0, 0);
        for (k = 0; k < 33; k++) send_point(24'($urandom), 24'($urandom), TAG_ON, 0, 0, 1);
        send_point(0, 0, TAG_ON, 1, 1, 0);

        // Long receiver hold-off while the sender keeps offering points.
        fork
            begin
                long_hold = 1;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            begin
                for (k = 0; k < 6; k++) send_contour(3, 0, 1);
                in_valid <= 0;
            end
        join
        @(posedge clk);

        // Random part: mostly contours from send_contour, some noise.
        n = 0;
        while (n < 205)
        begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
            if ($urandom_range(0, 5) == 0)
            begin
                for (int j = 0; j < k; j++)
                    send_point(rand_coord(), rand_coord(), 2'($urandom), j == k - 1 ||
                               $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0, 0);
            end
            else
            begin
                send_contour(k > 32 ? 32 : k, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 4) == 0);
            end
            n += k;
        end
        send_point(0, 0, TAG_ON, 1, 1, 0);
        in_valid <= 0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("glyph_outline_decomposer_test: done, clean");
        else
            $display("glyph_outline_decomposer_test: done, errors");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/god_pkg.sv
hw/rtl/god_datapath.sv
hw/rtl/god_ctrl.sv
hw/rtl/glyph_outline_decomposer.sv
verif/glyph_outline_decomposer_test.sv
